/* design/stdps_pkg.sv */
package stdps_pkg;

  localparam int VALUE_BITS_DEF = 30;

  localparam int FIRST_VALUE_W = 30;
  localparam int STRIDE_W      = 16;
  localparam int UPPER_LIMIT_W = 30;
  localparam int CFG_DATA_W    = 30;
  localparam int CFG_INDEX_W   = 2;
  localparam int CANDIDATE_W   = 30;

  localparam logic [FIRST_VALUE_W-1:0] FIRST_VALUE_RST = FIRST_VALUE_W'(1);
  localparam logic [STRIDE_W-1:0]      STRIDE_RST      = STRIDE_W'(2);
  localparam logic [UPPER_LIMIT_W-1:0] UPPER_LIMIT_RST = UPPER_LIMIT_W'(1000);

  localparam logic [CFG_INDEX_W-1:0] REG_FIRST_VALUE = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_STRIDE      = 2'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_UPPER_LIMIT = 2'd2;

  typedef struct packed {
    logic start;
    logic div_init;
    logic div_step;
    logic next_div;
    logic set_verdict;
    logic verdict;
    logic emit;
  } cmd_t;

  typedef struct packed {
    logic done;
    logic lt_two;
    logic sq_gt;
    logic div_last;
    logic rem_zero;
    logic out_free;
  } status_t;

endpackage

/* design/strided_trial_division_prime_scan_unit.sv */
// each item runs trial division through states CHECK, DIV and REM, then EMIT; divisors run from 2 until d*d exceeds it
// each divisor takes one bit-serial restoring remainder pass over VALUE_BITS bits in DIV, then a check in REM
// worst case near one billion is about 31623 divisors
// one item in work at a time; the next is taken while the last result waits
// synchronous active-low reset restores register defaults and the scan start, clears valid
module strided_trial_division_prime_scan_unit #(
  parameter int VALUE_BITS = stdps_pkg::VALUE_BITS_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              cfg_we,
  input  logic [stdps_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [stdps_pkg::CFG_DATA_W-1:0]  cfg_wdata,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic                              in_restart,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic [stdps_pkg::CANDIDATE_W-1:0] out_candidate,
  output logic                              out_is_prime,
  output logic                              out_done_res
);
  import stdps_pkg::*;

  cmd_t    cmd;
  status_t st;

  stdps_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .st       (st),
    .cmd      (cmd)
  );

  stdps_dp #(
    .VALUE_BITS (VALUE_BITS)
  ) u_dp (
    .clk           (clk),
    .rst_n         (rst_n),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_wdata     (cfg_wdata),
    .in_restart    (in_restart),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_candidate (out_candidate),
    .out_is_prime  (out_is_prime),
    .out_done_res  (out_done_res),
    .cmd           (cmd),
    .st            (st)
  );

endmodule

/* design/stdps_ctrl.sv */
module stdps_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  stdps_pkg::status_t st,
  output stdps_pkg::cmd_t    cmd
);
  import stdps_pkg::*;

  typedef enum logic [4:0] {
    S_IDLE  = 5'b00001,
    S_CHECK = 5'b00010,
    S_DIV   = 5'b00100,
    S_REM   = 5'b01000,
    S_EMIT  = 5'b10000
  } state_t;

  state_t state_r;
  state_t state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_ready  = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.start = 1'b1;
          state_nxt = S_CHECK;
        end
      end
      S_CHECK: begin
        if (st.done || st.lt_two) begin
          cmd.set_verdict = 1'b1;
          cmd.verdict     = 1'b0;
          state_nxt       = S_EMIT;
        end else if (st.sq_gt) begin
          cmd.set_verdict = 1'b1;
          cmd.verdict     = 1'b1;
          state_nxt       = S_EMIT;
        end else begin
          cmd.div_init = 1'b1;
          state_nxt    = S_DIV;
        end
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        if (st.div_last) begin
          state_nxt = S_REM;
        end
      end
      S_REM: begin
        if (st.rem_zero) begin
          cmd.set_verdict = 1'b1;
          cmd.verdict     = 1'b0;
          state_nxt       = S_EMIT;
        end else begin
          cmd.next_div = 1'b1;
          state_nxt    = S_CHECK;
        end
      end
      S_EMIT: begin
        if (st.out_free) begin
          cmd.emit  = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

endmodule

/* design/stdps_dp.sv */
module stdps_dp #(
  parameter int VALUE_BITS = stdps_pkg::VALUE_BITS_DEF
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 cfg_we,
  input  logic [stdps_pkg::CFG_INDEX_W-1:0]    cfg_index,
  input  logic [stdps_pkg::CFG_DATA_W-1:0]     cfg_wdata,
  input  logic                                 in_restart,
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output logic [stdps_pkg::CANDIDATE_W-1:0]    out_candidate,
  output logic                                 out_is_prime,
  output logic                                 out_done_res,
  input  stdps_pkg::cmd_t                      cmd,
  output stdps_pkg::status_t                   st
);
  import stdps_pkg::*;

  localparam int VB    = VALUE_BITS;
  localparam int DW    = (VB + 1) / 2 + 1;
  localparam int TW    = DW + 1;
  localparam int SQW   = VB + 1;
  localparam int SUM_W = ((VB > STRIDE_W) ? VB : STRIDE_W) + 1;
  localparam int CMP_W = (VB > UPPER_LIMIT_W) ? VB : UPPER_LIMIT_W;
  localparam int CNTW  = $clog2(VB);

  logic [FIRST_VALUE_W-1:0] first_value_r;
  logic [STRIDE_W-1:0]      stride_r;
  logic [UPPER_LIMIT_W-1:0] upper_limit_r;

  logic [VB-1:0]   next_cand_r;
  logic            finished_r;
  logic [VB-1:0]   cand_r;
  logic [VB-1:0]   cand_nxt;
  logic [DW-1:0]   d_r;
  logic [SQW-1:0]  d_sq_r;
  logic [DW-1:0]   rem_r;
  logic [DW-1:0]   rem_nxt;
  logic [VB-1:0]   sh_r;
  logic [CNTW-1:0] cnt_r;
  logic            verdict_r;

  logic                   out_valid_r;
  logic [CANDIDATE_W-1:0] out_cand_r;
  logic                   out_prime_r;
  logic                   out_done_r;

  logic [TW-1:0]    trial;
  logic             trial_ge;
  logic [SUM_W-1:0] sum;
  logic             sum_ovf;

  // candidate choice on a transfer
  assign cand_nxt = in_restart ? VB'(first_value_r) : next_cand_r;

  // one restoring remainder step
  assign trial    = {rem_r, sh_r[VB-1]};
  assign trial_ge = trial >= TW'(d_r);
  assign rem_nxt  = trial_ge ? DW'(trial - TW'(d_r)) : DW'(trial);

  assign sum     = SUM_W'(cand_r) + SUM_W'(stride_r);
  assign sum_ovf = (sum >> VB) != '0;

  assign st.done     = finished_r || (CMP_W'(cand_r) > CMP_W'(upper_limit_r));
  assign st.lt_two   = (cand_r >> 1) == '0;
  assign st.sq_gt    = d_sq_r > SQW'(cand_r);
  assign st.div_last = cnt_r == '0;
  assign st.rem_zero = rem_r == '0;
  assign st.out_free = !out_valid_r || out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      first_value_r <= FIRST_VALUE_RST;
      stride_r      <= STRIDE_RST;
      upper_limit_r <= UPPER_LIMIT_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_FIRST_VALUE: first_value_r <= FIRST_VALUE_W'(cfg_wdata);
        REG_STRIDE:      stride_r      <= STRIDE_W'(cfg_wdata);
        REG_UPPER_LIMIT: upper_limit_r <= UPPER_LIMIT_W'(cfg_wdata);
        default:         ;
      endcase
    end
  end

  // scan state and output valid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      next_cand_r <= VB'(FIRST_VALUE_RST);
      finished_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (cmd.start && in_restart) begin
        next_cand_r <= VB'(first_value_r);
        finished_r  <= 1'b0;
      end
      if (cmd.emit) begin
        if (st.done) begin
          finished_r <= 1'b1;
        end else if (sum_ovf) begin
          next_cand_r <= '1;
          finished_r  <= 1'b1;
        end else begin
          next_cand_r <= VB'(sum);
        end
      end
      if (cmd.emit) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.start) begin
      cand_r <= cand_nxt;
      d_r    <= DW'(2);
      d_sq_r <= SQW'(4);
    end
    if (cmd.next_div) begin
      d_r    <= d_r + DW'(1);
      d_sq_r <= d_sq_r + SQW'({d_r, 1'b1});
    end
    if (cmd.div_init) begin
      rem_r <= '0;
      sh_r  <= cand_r;
      cnt_r <= CNTW'(VB - 1);
    end else if (cmd.div_step) begin
      rem_r <= rem_nxt;
      sh_r  <= sh_r << 1;
      cnt_r <= cnt_r - CNTW'(1);
    end
    if (cmd.set_verdict) begin
      verdict_r <= cmd.verdict;
    end
    if (cmd.emit) begin
      out_cand_r  <= CANDIDATE_W'(cand_r);
      out_prime_r <= verdict_r && !st.done;
      out_done_r  <= st.done;
    end
  end

  assign out_valid     = out_valid_r;
  assign out_candidate = out_cand_r;
  assign out_is_prime  = out_prime_r;
  assign out_done_res  = out_done_r;

endmodule
